// ----- rtl/cdrb_pkg.sv -----
// ----------------------------------------------------------------------------
// cdrb_pkg
// Shared types, constants and the answer record table for the DNS reply
// builder.
// ----------------------------------------------------------------------------
package cdrb_pkg;

	localparam int MAX_QUERY   = 72;
	localparam int HDR_BYTES   = 12;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] FLAGS_RESP = 8'h84;
	localparam logic [7:0] PTR_HI     = 8'hC0;
	localparam logic [7:0] PTR_LO     = 8'h0C;
	localparam logic [7:0] TYPE_A     = 8'h01;
	localparam logic [7:0] CLASS_IN   = 8'h01;
	localparam logic [7:0] RDLEN_LO   = 8'h04;

	localparam logic [31:0] ADDR_RESET = 32'hC0A8_0401;
	localparam logic [31:0] TTL_RESET  = 32'h0000_0000;

	localparam logic [0:0] REG_ADDRESS = 1'b0;
	localparam logic [0:0] REG_TTL     = 1'b1;

	localparam logic [3:0] TRL_LAST = 4'd15;

	typedef struct packed {
		logic [7:0] data;
		logic       trailer;
	} cdrb_entry_t;

	function automatic logic [7:0] trailer_byte(
		input logic [3:0]  idx,
		input logic [31:0] ttl,
		input logic [31:0] addr
	);
		logic [7:0] b;
		case (idx)
			4'd0: b = PTR_HI;
			4'd1: b = PTR_LO;
			4'd2: b = 8'h00;
			4'd3: b = TYPE_A;
			4'd4: b = 8'h00;
			4'd5: b = CLASS_IN;
			4'd6: b = ttl[31:24];
			4'd7: b = ttl[23:16];
			4'd8: b = ttl[15:8];
			4'd9: b = ttl[7:0];
			4'd10: b = 8'h00;
			4'd11: b = RDLEN_LO;
			4'd12: b = addr[31:24];
			4'd13: b = addr[23:16];
			4'd14: b = addr[15:8];
			4'd15: b = addr[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/captive_dns_reply_builder.sv -----
// ----------------------------------------------------------------------------
// captive_dns_reply_builder
// Streams a DNS reply that answers every question with one IPv4 address.
// ----------------------------------------------------------------------------
// The block takes one query byte per cycle while it is not full and gives back
// one reply byte per cycle while pop is held and a byte is ready. A kept query
// byte is registered in the queue and then in the output register before it
// can be popped. A kept last byte is followed by the 16 bytes of the answer
// record; during the record the front keeps taking bytes until the internal
// queue of QUEUE_DEPTH entries is full. Dropped queries use input cycles only.
module captive_dns_reply_builder import cdrb_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  query_byte,
	input  logic [9:0]  query_length,
	input  logic        is_last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  reply_byte,
	output logic        is_last_reply,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] address_q;
	logic [31:0] ttl_q;
	logic        enq;
	cdrb_entry_t enq_entry;
	logic        deq;
	cdrb_entry_t deq_entry;
	logic        q_empty;
	logic        accept;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= ADDR_RESET;
			ttl_q     <= TTL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADDRESS: address_q <= cfg_data;
				REG_TTL:     ttl_q     <= cfg_data;
				default:     address_q <= address_q;
			endcase
		end
	end

	cdrb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.query_byte   (query_byte),
		.query_length (query_length),
		.is_last_byte (is_last_byte),
		.enq          (enq),
		.enq_entry    (enq_entry)
	);

	cdrb_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (enq),
		.enq_entry (enq_entry),
		.deq       (deq),
		.deq_entry (deq_entry),
		.full      (full),
		.empty     (q_empty)
	);

	cdrb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.deq_entry      (deq_entry),
		.q_empty        (q_empty),
		.deq            (deq),
		.answer_address (address_q),
		.answer_ttl     (ttl_q),
		.pop            (pop),
		.empty          (empty),
		.reply_byte     (reply_byte),
		.is_last_reply  (is_last_reply)
	);

endmodule

// ----- rtl/cdrb_front.sv -----
// ----------------------------------------------------------------------------
// cdrb_front
// Accepts query bytes, drops out-of-range queries and rewrites the header.
// ----------------------------------------------------------------------------
module cdrb_front import cdrb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  query_byte,
	input  logic [9:0]  query_length,
	input  logic        is_last_byte,
	output logic        enq,
	output cdrb_entry_t enq_entry
);

	logic [3:0] byte_position_q;
	logic [7:0] count_high_q;
	logic [7:0] count_low_q;
	logic       keep;
	logic [7:0] hdr_byte;

	assign keep = (query_length >= 10'(HDR_BYTES)) && (query_length < 10'(MAX_QUERY));

	always_comb begin
		case (byte_position_q)
			4'd0, 4'd1, 4'd4, 4'd5: hdr_byte = query_byte;
			4'd2: hdr_byte = FLAGS_RESP | {7'd0, query_byte[0]};
			4'd6: hdr_byte = count_high_q;
			4'd7: hdr_byte = count_low_q;
			4'd3, 4'd8, 4'd9, 4'd10, 4'd11: hdr_byte = 8'h00;
			default: hdr_byte = query_byte;
		endcase
	end

	assign enq               = accept && keep;
	assign enq_entry.data    = hdr_byte;
	assign enq_entry.trailer = is_last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= 4'd0;
			count_high_q    <= 8'd0;
			count_low_q     <= 8'd0;
		end else if (accept) begin
			if (is_last_byte) begin
				byte_position_q <= 4'd0;
			end else if (byte_position_q < 4'(HDR_BYTES)) begin
				byte_position_q <= byte_position_q + 4'd1;
			end
			if (keep && byte_position_q == 4'd4) begin
				count_high_q <= query_byte;
			end
			if (keep && byte_position_q == 4'd5) begin
				count_low_q <= query_byte;
			end
		end
	end

endmodule

// ----- rtl/cdrb_queue.sv -----
// ----------------------------------------------------------------------------
// cdrb_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module cdrb_queue import cdrb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        enq,
	input  cdrb_entry_t enq_entry,
	input  logic        deq,
	output cdrb_entry_t deq_entry,
	output logic        full,
	output logic        empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cdrb_entry_t      entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_enq;
	logic             do_deq;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_enq    = enq && !full;
	assign do_deq    = deq && !empty;
	assign deq_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_enq) begin
			entries_q[wr_ptr_q] <= enq_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_enq && !do_deq) begin
				count_q <= count_q + 1'b1;
			end else if (do_deq && !do_enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/cdrb_back.sv -----
// ----------------------------------------------------------------------------
// cdrb_back
// Sends queued reply bytes and appends the answer record after a last byte.
// ----------------------------------------------------------------------------
module cdrb_back import cdrb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cdrb_entry_t deq_entry,
	input  logic        q_empty,
	output logic        deq,
	input  logic [31:0] answer_address,
	input  logic [31:0] answer_ttl,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  reply_byte,
	output logic        is_last_reply
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       trl_active_q;
	logic [3:0] trl_idx_q;
	logic       load;

	assign load          = !out_valid_q || pop;
	assign deq           = load && !trl_active_q && !q_empty;
	assign empty         = !out_valid_q;
	assign reply_byte    = out_byte_q;
	assign is_last_reply = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
			trl_active_q <= 1'b0;
			trl_idx_q    <= 4'd0;
		end else if (load) begin
			if (trl_active_q) begin
				out_valid_q <= 1'b1;
				out_last_q  <= (trl_idx_q == TRL_LAST);
				trl_idx_q   <= trl_idx_q + 4'd1;
				if (trl_idx_q == TRL_LAST) begin
					trl_active_q <= 1'b0;
				end
			end else if (!q_empty) begin
				out_valid_q  <= 1'b1;
				out_last_q   <= 1'b0;
				trl_active_q <= deq_entry.trailer;
				trl_idx_q    <= 4'd0;
			end else begin
				out_valid_q <= 1'b0;
				out_last_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (trl_active_q) begin
				out_byte_q <= trailer_byte(trl_idx_q, answer_ttl, answer_address);
			end else begin
				out_byte_q <= deq_entry.data;
			end
		end
	end

endmodule

// ----- rtl/cdrb_checker.sv -----
// ----------------------------------------------------------------------------
// cdrb_checker
// Port-level checks for the DNS reply builder, bound to the top level.
// ----------------------------------------------------------------------------
module cdrb_checker import cdrb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  reply_byte,
	input logic        is_last_reply,
	input logic        cfg_we,
	input logic [0:0]  cfg_index,
	input logic [31:0] cfg_data
);

	logic [31:0] addr_shadow_q;
	logic [7:0]  prev_beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_shadow_q <= ADDR_RESET;
			prev_beat_q   <= 8'd0;
		end else begin
			if (cfg_we && cfg_index == REG_ADDRESS) begin
				addr_shadow_q <= cfg_data;
			end
			if (pop && !empty) begin
				prev_beat_q <= reply_byte;
			end
		end
	end

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(reply_byte) && $stable(is_last_reply)))
		else $error("Waiting reply beat changed before it was taken.");

	a_out_of_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (empty && !full))
		else $error("Block is not empty right after reset.");

	a_last_is_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_last_reply) |-> (reply_byte == addr_shadow_q[7:0]))
		else $error("Final reply beat is not the low address byte.");

	a_before_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && is_last_reply) |-> (prev_beat_q == addr_shadow_q[15:8]))
		else $error("Beat before the final one is not the third address byte.");

endmodule

bind captive_dns_reply_builder cdrb_checker u_cdrb_checker (.*);

// ----- tb/tb_captive_dns_reply_builder.sv -----
// ----------------------------------------------------------------------------
// tb_captive_dns_reply_builder
// Streams DNS queries into the reply builder byte by byte and checks every
// reply beat against a cycle-free prediction of the rewritten header, the
// passed-through question and the appended A record. Directed queries cover
// the length limits, truncated and mislabeled packets and the replay of the
// stored question count. Random traffic follows, mostly well-formed queries
// with some noise, under several answer address and TTL settings. Both the
// query and the reply side pause at random.
// ----------------------------------------------------------------------------
module tb_captive_dns_reply_builder;
	import cdrb_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int SETTLE_TICKS = 24;
	localparam int RANDOM_BYTES = 200;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_beat_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        push          = 1'b0;
	logic        full;
	logic [7:0]  query_byte    = 8'h00;
	logic [9:0]  query_length  = 10'd0;
	logic        is_last_byte  = 1'b0;
	logic        empty;
	logic        pop           = 1'b0;
	logic [7:0]  reply_byte;
	logic        is_last_reply;
	logic        cfg_we        = 1'b0;
	logic [0:0]  cfg_index     = REG_ADDRESS;
	logic [31:0] cfg_data      = 32'h0;

	reply_beat_t expected_reply[$];
	reply_beat_t head_beat;

	logic [3:0]  hdr_pos     = 4'd0;
	logic [7:0]  qdcount_hi  = 8'h00;
	logic [7:0]  qdcount_lo  = 8'h00;
	logic [31:0] cur_address = ADDR_RESET;
	logic [31:0] cur_ttl     = TTL_RESET;

	int  cycle_count   = 0;
	int  error_count   = 0;
	int  bytes_sent    = 0;
	int  kept_bytes    = 0;
	int  packets_sent  = 0;
	int  beats_checked = 0;
	int  settings_used = 1;
	int  pop_stall     = 0;
	bit  no_idle       = 1'b0;

	captive_dns_reply_builder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.query_byte   (query_byte),
		.query_length (query_length),
		.is_last_byte (is_last_byte),
		.empty        (empty),
		.pop          (pop),
		.reply_byte   (reply_byte),
		.is_last_reply(is_last_reply),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("captive_dns_reply_builder: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] header_rewrite(input logic [3:0] pos, input logic [7:0] b);
		case (pos)
			4'd0, 4'd1: return b;
			4'd2: return FLAGS_RESP | {7'd0, b[0]};
			4'd4: begin
				qdcount_hi = b;
				return b;
			end
			4'd5: begin
				qdcount_lo = b;
				return b;
			end
			4'd6: return qdcount_hi;
			4'd7: return qdcount_lo;
			4'd3, 4'd8, 4'd9, 4'd10, 4'd11: return 8'h00;
			default: return b;
		endcase
	endfunction

	function automatic void predict_reply(input logic [7:0] b, input logic [9:0] len,
			input logic last);
		logic       keep;
		logic [7:0] rec [16];
		keep = (len >= HDR_BYTES) && (len < MAX_QUERY);
		if (keep) expected_reply.push_back(reply_beat_t'{header_rewrite(hdr_pos, b), 1'b0});
		if (last) hdr_pos = 4'd0;
		else if (hdr_pos < HDR_BYTES) hdr_pos = hdr_pos + 4'd1;
		if (keep && last) begin
			rec = '{PTR_HI, PTR_LO, 8'h00, TYPE_A, 8'h00, CLASS_IN,
				cur_ttl[31:24], cur_ttl[23:16], cur_ttl[15:8], cur_ttl[7:0],
				8'h00, RDLEN_LO,
				cur_address[31:24], cur_address[23:16], cur_address[15:8],
				cur_address[7:0]};
			foreach (rec[i]) expected_reply.push_back(reply_beat_t'{rec[i], i == 15});
		end
		if (keep) kept_bytes++;
	endfunction

	// Reply side: pops with random stalls and checks each accepted beat.
	always @(posedge clk) begin
		if (pop && !empty) begin
			if (expected_reply.size() == 0) begin
				$error("reply beat with nothing expected: reply_byte %02h", reply_byte);
				error_count++;
			end else begin
				head_beat = expected_reply.pop_front();
				beats_checked++;
				if (reply_byte !== head_beat.data) begin
					$error("reply_byte: expected %02h, actual %02h", head_beat.data,
						reply_byte);
					error_count++;
				end
				if (is_last_reply !== head_beat.last) begin
					$error("is_last_reply: expected %0b, actual %0b", head_beat.last,
						is_last_reply);
					error_count++;
				end
			end
		end
		if (pop_stall != 0) begin
			pop <= 1'b0;
			pop_stall--;
		end else begin
			pop <= arst_n;
			pop_stall = pick_gap();
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic [9:0] len, input logic last);
		int gap;
		push         <= 1'b1;
		query_byte   <= b;
		query_length <= len;
		is_last_byte <= last;
		do @(posedge clk); while (full);
		predict_reply(b, len, last);
		bytes_sent++;
		if (last) packets_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_run(input logic [9:0] len, input int n, input int fill,
			input logic last);
		for (int i = 0; i < n; i++)
			send_byte(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill), len,
				last && (i == n - 1));
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (expected_reply.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_answer(input logic [31:0] addr, input logic [31:0] ttl);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_ADDRESS;
		cfg_data  <= addr;
		@(posedge clk);
		cfg_index <= REG_TTL;
		cfg_data  <= ttl;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_address = addr;
		cur_ttl     = ttl;
		settings_used++;
	endtask

	task automatic test_minimum_query();
		send_run(10'd12, 12, 8'hFF, 1'b1);
	endtask

	task automatic test_truncated_query();
		send_run(10'd20, 3, 8'h00, 1'b1);
	endtask

	task automatic test_dropped_queries();
		send_run(10'd11, 3, -1, 1'b1);
		send_run(10'd512, 1, 8'hFF, 1'b1);
		send_run(10'd72, 1, 8'h00, 1'b1);
	endtask

	// Count bytes carry a dropped length, so positions 6 and 7 replay the
	// question count stored by the first query.
	task automatic test_count_replay();
		send_run(10'd20, 4, 8'h3C, 1'b0);
		send_run(10'd5, 2, 8'h00, 1'b0);
		send_run(10'd20, 2, 8'hA5, 1'b1);
	endtask

	task automatic test_answer_extremes();
		set_answer(32'h0000_0000, 32'hFFFF_FFFF);
		send_run(10'($urandom_range(12, 24)), 14, -1, 1'b1);
		set_answer(32'hFFFF_FFFF, 32'h0000_0000);
		send_run(10'd71, 13, -1, 1'b1);
	endtask

	task automatic test_random_traffic();
		int         kind;
		int         n;
		int         pkt;
		logic [9:0] len;
		pkt = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			no_idle = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				len = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(41, 71))
					: 10'($urandom_range(12, 40));
				send_run(len, int'(len), -1, 1'b1);
			end else if (kind == 8) begin
				len = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 11))
					: 10'($urandom_range(72, 512));
				send_run(len, $urandom_range(1, 20), -1, 1'b1);
			end else begin
				n = $urandom_range(1, 30);
				for (int i = 0; i < n; i++) begin
					len = ($urandom_range(0, 2) == 0) ? 10'($urandom_range(0, 512))
						: 10'($urandom_range(12, 71));
					send_byte(8'($urandom_range(0, 255)), len,
						(i == n - 1) && ($urandom_range(0, 3) != 0));
				end
			end
			pkt++;
			if (pkt % 5 == 0) begin
				no_idle = 1'b0;
				set_answer($urandom, $urandom);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_minimum_query();
		test_truncated_query();
		test_dropped_queries();
		test_count_replay();
		test_answer_extremes();
		test_random_traffic();
		wait_idle();
		$display("Sent %0d query bytes in %0d packets, %0d of them in kept queries.",
			bytes_sent, packets_sent, kept_bytes);
		$display("Checked %0d reply beats under %0d answer settings.", beats_checked,
			settings_used);
		if (error_count == 0 && expected_reply.size() == 0) begin
			$display("captive_dns_reply_builder: match");
		end else begin
			$display("captive_dns_reply_builder: mismatch");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cdrb_pkg.sv
rtl/cdrb_front.sv
rtl/cdrb_queue.sv
rtl/cdrb_back.sv
rtl/captive_dns_reply_builder.sv
rtl/cdrb_checker.sv
tb/tb_captive_dns_reply_builder.sv
